### rtl/core/itse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itse_pkg
// Shared types, constants and helpers of the taxel spike encoder.
// ----------------------------------------------------------------------------
package itse_pkg;

    // Configuration register indexes
    typedef enum logic [3:0] {
        REG_CURRENT_GAIN         = 4'd0,
        REG_SPIKE_THRESHOLD      = 4'd1,
        REG_RESET_POTENTIAL      = 4'd2,
        REG_RECOVERY_JUMP        = 4'd3,
        REG_FLOOR_POTENTIAL      = 4'd4,
        REG_TIME_STEP            = 4'd5,
        REG_RECOVERY_RATE        = 4'd6,
        REG_RECOVERY_SENSITIVITY = 4'd7
    } reg_idx_t;

    // Configuration values as seen by the datapath
    typedef struct packed {
        logic        [23:0] current_gain;
        logic signed [7:0]  spike_threshold;
        logic signed [7:0]  reset_potential;
        logic        [7:0]  recovery_jump;
        logic signed [7:0]  floor_potential;
        logic        [31:0] time_step;
        logic        [15:0] recovery_rate;
        logic        [15:0] recovery_sensitivity;
    } cfg_t;

    // Register reset values
    localparam logic        [23:0] GAIN_RST      = 24'd5281291;
    localparam logic signed [7:0]  THR_RST       = 8'sd30;
    localparam logic signed [7:0]  RSTPOT_RST    = -8'sd65;
    localparam logic        [7:0]  JUMP_RST      = 8'd8;
    localparam logic signed [7:0]  FLOOR_RST     = -8'sd30;
    localparam logic        [31:0] DT_RST        = 32'd4294967;
    localparam logic        [15:0] RATE_RST      = 16'd1311;
    localparam logic        [15:0] SENS_RST      = 16'd13107;

    // Model constants in fixed point
    localparam logic        [13:0] QUAD_COEF     = 14'd10486;     // 0.04 in Q0.18
    localparam logic signed [31:0] CONST_TERM_Q  = 32'sd9175040;  // 140.0 in Q16.16
    localparam logic signed [31:0] V_RESET_Q     = -32'sd1966080; // -30.0 in Q16.16
    localparam logic        [39:0] CUR_MAX       = 40'h007FFFFFFF;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -66'sh0_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/core/itse_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itse_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface itse_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/itse_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itse_in_if
// Sample channel: taxel index, converter code and timestamp.
// ----------------------------------------------------------------------------
interface itse_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  taxel_index;
    logic [11:0] adc_code;
    logic [31:0] timestamp;

    modport source (output valid, output taxel_index, output adc_code, output timestamp,
                    input ready);
    modport sink   (input valid, input taxel_index, input adc_code, input timestamp,
                    output ready);
endinterface
`default_nettype wire

### rtl/core/itse_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itse_out_if
// Result channel: spike flag, channel, spike time and new potential.
// ----------------------------------------------------------------------------
interface itse_out_if;
    logic               valid;
    logic               ready;
    logic               spike;
    logic [3:0]         channel;
    logic [31:0]        spike_time;
    logic signed [31:0] membrane_potential;

    modport source (output valid, output spike, output channel, output spike_time,
                    output membrane_potential, input ready);
    modport sink   (input valid, input spike, input channel, input spike_time,
                    input membrane_potential, output ready);
endinterface
`default_nettype wire

### rtl/core/itse_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itse_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module itse_ram #(
    parameter int WIDTH = 76,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/core/itse_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itse_cfg
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module itse_cfg (
    input  wire logic     clk,
    input  wire logic     rst_n,
    itse_cfg_if.sink      cfg,
    output itse_pkg::cfg_t regs
);

    itse_pkg::cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.current_gain         <= itse_pkg::GAIN_RST;
            regs_reg.spike_threshold      <= itse_pkg::THR_RST;
            regs_reg.reset_potential      <= itse_pkg::RSTPOT_RST;
            regs_reg.recovery_jump        <= itse_pkg::JUMP_RST;
            regs_reg.floor_potential      <= itse_pkg::FLOOR_RST;
            regs_reg.time_step            <= itse_pkg::DT_RST;
            regs_reg.recovery_rate        <= itse_pkg::RATE_RST;
            regs_reg.recovery_sensitivity <= itse_pkg::SENS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                itse_pkg::REG_CURRENT_GAIN:
                    regs_reg.current_gain <= cfg.data[23:0];
                itse_pkg::REG_SPIKE_THRESHOLD:
                    regs_reg.spike_threshold <= cfg.data[7:0];
                itse_pkg::REG_RESET_POTENTIAL:
                    regs_reg.reset_potential <= cfg.data[7:0];
                itse_pkg::REG_RECOVERY_JUMP:
                    regs_reg.recovery_jump <= cfg.data[7:0];
                itse_pkg::REG_FLOOR_POTENTIAL:
                    regs_reg.floor_potential <= cfg.data[7:0];
                itse_pkg::REG_TIME_STEP:
                    regs_reg.time_step <= cfg.data;
                itse_pkg::REG_RECOVERY_RATE:
                    regs_reg.recovery_rate <= cfg.data[15:0];
                itse_pkg::REG_RECOVERY_SENSITIVITY:
                    regs_reg.recovery_sensitivity <= cfg.data[15:0];
                default:
                    regs_reg <= regs_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/core/izhikevich_taxel_spike_encoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// izhikevich_taxel_spike_encoder_core
// Per-taxel Izhikevich neuron that turns converter samples into spikes.
// ----------------------------------------------------------------------------
// Channels: cfg writes one register per item (always ready); sample takes one
// item of taxel index, code and timestamp; result gives one item per sample
// with spike flag, channel, spike time (zero without spike) and new potential.
// Per-taxel state (last code, potential, recovery) lives in one RAM with a
// registered read; a valid bit per taxel supplies the reset state until the
// taxel is first written, so no clearing pass is needed.
// The result is computed along the chain of RAM read, three dependent
// multiplies and the final saturate/threshold step.
// Throughput: one item per cycle while the result is taken and no hazard
// holds. A sample for a taxel still in flight in the first five stages is
// held off until its write-back lands.
// Reset clears the pipeline, the valid bits and the registers to defaults.
// A stalled result stage holds; earlier stages keep filling bubbles and
// samples are still taken until the pipeline is full.
// ----------------------------------------------------------------------------
module izhikevich_taxel_spike_encoder_core #(
    parameter int TAXEL_COUNT = 16,
    parameter int ADC_BITS    = 12
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    itse_cfg_if.sink   cfg,
    itse_in_if.sink    sample,
    itse_out_if.source result
);

    localparam int IDX_W = $clog2(TAXEL_COUNT);
    localparam int RED_W = (IDX_W > 4) ? IDX_W : 4;
    localparam int CMP_W = RED_W + 1;
    localparam int MEM_W = ADC_BITS + 64;

    itse_pkg::cfg_t regs;

    itse_cfg u_cfg (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .regs (regs)
    );

    // ------------------------------------------------------------------
    // Input side: index reduction and hazard check
    // ------------------------------------------------------------------
    logic [RED_W-1:0]    red;
    logic [IDX_W-1:0]    idx0;
    logic [ADC_BITS-1:0] code0;
    logic                hazard;
    logic                accept;

    always_comb
    begin
        red = RED_W'(sample.taxel_index);
        for (int k = 0; k < 8; k++)
        begin
            if (CMP_W'(red) >= CMP_W'(TAXEL_COUNT))
            begin
                red = RED_W'(CMP_W'(red) - CMP_W'(TAXEL_COUNT));
            end
        end
        idx0  = red[IDX_W-1:0];
        code0 = ADC_BITS'(sample.adc_code);
    end

    // Stage registers
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg, s6_vld_reg;
    logic take1, take2, take3, take4, take5, take6;

    logic [IDX_W-1:0]    idx1_reg, idx2_reg, idx3_reg, idx4_reg, idx5_reg;
    logic [ADC_BITS-1:0] code1_reg, code2_reg, code3_reg, code4_reg, code5_reg;
    logic [31:0]         stamp1_reg, stamp2_reg, stamp3_reg, stamp4_reg, stamp5_reg;
    logic                hit1_reg;

    logic signed [31:0]  v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [31:0]  u2_reg, u3_reg, u4_reg, u5_reg;
    logic        [63:0]  p_sq2_reg;
    logic signed [48:0]  p_bv2_reg;
    logic        [39:0]  p_cur2_reg;
    logic        [61:0]  quad_prod3_reg;
    logic signed [31:0]  inner3_reg;
    logic        [31:0]  cur3_reg;
    logic signed [31:0]  sum4_reg;
    logic signed [48:0]  au_prod4_reg;
    logic signed [64:0]  prod_v5_reg;
    logic signed [64:0]  prod_u5_reg;

    logic                spike6_reg;
    logic [3:0]          chan6_reg;
    logic [31:0]         time6_reg;
    logic signed [31:0]  mp6_reg;

    logic [TAXEL_COUNT-1:0] vld_reg;

    // Hold off a sample whose taxel is still being updated
    assign hazard = (s1_vld_reg && (idx1_reg == idx0)) ||
                    (s2_vld_reg && (idx2_reg == idx0)) ||
                    (s3_vld_reg && (idx3_reg == idx0)) ||
                    (s4_vld_reg && (idx4_reg == idx0)) ||
                    (s5_vld_reg && (idx5_reg == idx0));

    // Advance each stage when it is empty or its item moves on
    assign take6 = !s6_vld_reg || result.ready;
    assign take5 = !s5_vld_reg || take6;
    assign take4 = !s4_vld_reg || take5;
    assign take3 = !s3_vld_reg || take4;
    assign take2 = !s2_vld_reg || take3;
    assign take1 = !s1_vld_reg || take2;

    assign sample.ready = take1 && !hazard;
    assign accept       = sample.valid && sample.ready;

    // ------------------------------------------------------------------
    // State memory
    // ------------------------------------------------------------------
    logic [MEM_W-1:0] rdata;
    logic [MEM_W-1:0] wdata;
    logic             we;

    itse_ram #(
        .WIDTH(MEM_W),
        .DEPTH(TAXEL_COUNT)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(idx5_reg),
        .wdata(wdata),
        .re   (accept),
        .raddr(idx0),
        .rdata(rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: state select, difference, first products
    // ------------------------------------------------------------------
    logic [ADC_BITS-1:0] prev1;
    logic [ADC_BITS-1:0] diff1;
    logic signed [31:0]  v1, u1;
    logic        [31:0]  av1;

    always_comb
    begin
        prev1 = hit1_reg ? rdata[MEM_W-1 -: ADC_BITS] : {ADC_BITS{1'b1}};
        v1    = hit1_reg ? $signed(rdata[63:32]) : itse_pkg::V_RESET_Q;
        u1    = hit1_reg ? $signed(rdata[31:0]) : 32'sd0;
        diff1 = (code1_reg > prev1) ? (code1_reg - prev1) : (prev1 - code1_reg);
        av1   = v1[31] ? 32'(-v1) : 32'(v1);
    end

    // ------------------------------------------------------------------
    // Stage 2: square scaling, b*v - u, current saturation
    // ------------------------------------------------------------------
    logic        [47:0] sq2;
    logic signed [32:0] bv2;

    always_comb
    begin
        sq2 = p_sq2_reg[63:16];
        bv2 = $signed(p_bv2_reg[48:16]);
    end

    // ------------------------------------------------------------------
    // Stage 3: derivative sum, a*(b*v - u)
    // ------------------------------------------------------------------
    logic [43:0]        quad3;
    logic signed [65:0] sum3_w;

    always_comb
    begin
        quad3  = quad_prod3_reg[61:18];
        sum3_w = 66'($signed({1'b0, quad3})) + (66'(v3_reg) <<< 2) + 66'(v3_reg)
               + 66'(itse_pkg::CONST_TERM_Q) - 66'(u3_reg)
               + 66'($signed({1'b0, cur3_reg}));
    end

    // ------------------------------------------------------------------
    // Stage 4: scale by the time step
    // ------------------------------------------------------------------
    logic signed [31:0] au4;
    logic signed [64:0] dt4;

    always_comb
    begin
        au4 = itse_pkg::sat32(66'($signed(au_prod4_reg[48:16])));
        dt4 = $signed({33'b0, regs.time_step});
    end

    // ------------------------------------------------------------------
    // Stage 5: update, floor, threshold and write back
    // ------------------------------------------------------------------
    logic signed [31:0] nv_raw5, nu_raw5, nv_fl5, nv5, nu5;
    logic signed [31:0] floor_q, thr_q, rst_q;
    logic               fired5;

    always_comb
    begin
        floor_q = {{8{regs.floor_potential[7]}}, regs.floor_potential, 16'b0};
        thr_q   = {{8{regs.spike_threshold[7]}}, regs.spike_threshold, 16'b0};
        rst_q   = {{8{regs.reset_potential[7]}}, regs.reset_potential, 16'b0};
        nv_raw5 = itse_pkg::sat32(66'($signed(prod_v5_reg[64:32])) + 66'(v5_reg));
        nu_raw5 = itse_pkg::sat32(66'($signed(prod_u5_reg[64:32])) + 66'(u5_reg));
        nv_fl5  = (nv_raw5 < floor_q) ? floor_q : nv_raw5;
        fired5  = (nv_fl5 >= thr_q);
        nv5     = fired5 ? rst_q : nv_fl5;
        nu5     = fired5 ? itse_pkg::sat32(66'(nu_raw5)
                                           + $signed({42'b0, regs.recovery_jump, 16'b0}))
                         : nu_raw5;
        wdata   = {code5_reg, nv5, nu5};
        we      = s5_vld_reg && take6;
    end

    // ------------------------------------------------------------------
    // Control: stage valids and taxel valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            vld_reg    <= '0;
        end
        else
        begin
            if (take1) s1_vld_reg <= accept;
            if (take2) s2_vld_reg <= s1_vld_reg;
            if (take3) s3_vld_reg <= s2_vld_reg;
            if (take4) s4_vld_reg <= s3_vld_reg;
            if (take5) s5_vld_reg <= s4_vld_reg;
            if (take6) s6_vld_reg <= s5_vld_reg;
            if (we)    vld_reg[idx5_reg] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            idx1_reg   <= idx0;
            code1_reg  <= code0;
            stamp1_reg <= sample.timestamp;
            hit1_reg   <= vld_reg[idx0];
        end
        if (take2)
        begin
            idx2_reg   <= idx1_reg;
            code2_reg  <= code1_reg;
            stamp2_reg <= stamp1_reg;
            v2_reg     <= v1;
            u2_reg     <= u1;
            p_sq2_reg  <= 64'(av1) * 64'(av1);
            p_bv2_reg  <= 49'(v1) * $signed({33'b0, regs.recovery_sensitivity});
            p_cur2_reg <= 40'(regs.current_gain) * 40'(diff1);
        end
        if (take3)
        begin
            idx3_reg       <= idx2_reg;
            code3_reg      <= code2_reg;
            stamp3_reg     <= stamp2_reg;
            v3_reg         <= v2_reg;
            u3_reg         <= u2_reg;
            quad_prod3_reg <= 62'(sq2) * 62'(itse_pkg::QUAD_COEF);
            inner3_reg     <= itse_pkg::sat32(66'(bv2) - 66'(u2_reg));
            cur3_reg       <= (p_cur2_reg > itse_pkg::CUR_MAX) ? 32'h7FFF_FFFF
                                                                : p_cur2_reg[31:0];
        end
        if (take4)
        begin
            idx4_reg     <= idx3_reg;
            code4_reg    <= code3_reg;
            stamp4_reg   <= stamp3_reg;
            v4_reg       <= v3_reg;
            u4_reg       <= u3_reg;
            sum4_reg     <= itse_pkg::sat32(sum3_w);
            au_prod4_reg <= 49'(inner3_reg) * $signed({33'b0, regs.recovery_rate});
        end
        if (take5)
        begin
            idx5_reg    <= idx4_reg;
            code5_reg   <= code4_reg;
            stamp5_reg  <= stamp4_reg;
            v5_reg      <= v4_reg;
            u5_reg      <= u4_reg;
            prod_v5_reg <= 65'(sum4_reg) * dt4;
            prod_u5_reg <= 65'(au4) * dt4;
        end
        if (take6)
        begin
            spike6_reg <= fired5;
            chan6_reg  <= 4'(idx5_reg);
            time6_reg  <= fired5 ? stamp5_reg : 32'd0;
            mp6_reg    <= nv5;
        end
    end

    // Result channel
    assign result.valid              = s6_vld_reg;
    assign result.spike              = spike6_reg;
    assign result.channel            = chan6_reg;
    assign result.spike_time         = time6_reg;
    assign result.membrane_potential = mp6_reg;

endmodule
`default_nettype wire

### rtl/core/itse_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itse_checker
// Port-level checks of the taxel spike encoder, bound to the top level.
// ----------------------------------------------------------------------------
module itse_checker #(
    parameter int TAXEL_COUNT = 16
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        spike,
    input wire logic [3:0]  channel,
    input wire logic [31:0] spike_time
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    // A result without spike carries no time
    a_no_spike_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !spike |-> spike_time == 32'd0)
        else $error("spike time set without spike");

    // Channel stays within the taxel count
    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(channel) < 32'(TAXEL_COUNT))
        else $error("channel beyond taxel count");

    // No result item during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind izhikevich_taxel_spike_encoder_core itse_checker #(
    .TAXEL_COUNT(TAXEL_COUNT)
) u_itse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .spike     (result.spike),
    .channel   (result.channel),
    .spike_time(result.spike_time)
);
`default_nettype wire
